[sv/vertical_gradient_peak_marker_assert.svh]
// Assertion macros for the vertical gradient peak marker.
`ifndef VERTICAL_GRADIENT_PEAK_MARKER_ASSERT_SVH
`define VERTICAL_GRADIENT_PEAK_MARKER_ASSERT_SVH
`ifndef SYNTHESIS
`define VGPM_ASSERT(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define VGPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VGPM_ASSERT(label, clk, rst_n, expr, msg)
`define VGPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/vgpm_pkg.sv]
`default_nettype none
package vgpm_pkg;

  localparam int MAX_SIZE_X  = 256;
  localparam int MAX_SIZE_Y  = 256;
  localparam int MAX_SIZE_Z  = 1024;
  localparam int MIN_SIZE_Z  = 5;
  localparam int SAMPLE_BITS = 24;

  localparam int X_BITS     = $clog2(MAX_SIZE_X);
  localparam int Y_BITS     = $clog2(MAX_SIZE_Y);
  localparam int CELL_BITS  = X_BITS + Y_BITS;
  localparam int PLANE_SIZE = MAX_SIZE_X * MAX_SIZE_Y;

  // register field widths
  localparam int SX_BITS    = 9;
  localparam int SY_BITS    = 9;
  localparam int SZ_BITS    = 11;
  localparam int SCALE_BITS = 16;

  // plane counter also covers the two drain planes
  localparam int Z_BITS  = SZ_BITS;
  localparam int ZE_BITS = Z_BITS + 1;

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + SCALE_BITS + 1;
  localparam int GRAD_BITS = SAMPLE_BITS + 1;

  localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(128);
  localparam int ROUND_SHIFT = 8;
  localparam logic signed [PROD_BITS-1:0] Q_MAX =
    PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_BITS-1:0] Q_MIN =
    PROD_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [SX_BITS-1:0]    RST_SIZE_X = SX_BITS'(256);
  localparam logic [SY_BITS-1:0]    RST_SIZE_Y = SY_BITS'(256);
  localparam logic [SZ_BITS-1:0]    RST_SIZE_Z = SZ_BITS'(1024);
  localparam logic [SCALE_BITS-1:0] RST_SCALE  = SCALE_BITS'(256);

  typedef enum logic [2:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_DUMMY_LIMIT,
    REG_GRADIENT_SCALE
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic    dummy;
    sample_t value;
  } grad_t;

  typedef struct packed {
    logic [SX_BITS-1:0]    size_x;
    logic [SY_BITS-1:0]    size_y;
    logic [SZ_BITS-1:0]    size_z;
    sample_t               dummy_limit;
    logic [SCALE_BITS-1:0] gradient_scale;
    logic                  restart;
  } cfg_t;

endpackage
`default_nettype wire

[sv/vgpm_ram.sv]
`default_nettype none
module vgpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/vgpm_cfg.sv]
`default_nettype none
module vgpm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vgpm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [vgpm_pkg::DATA_BITS-1:0] pwdata,
  output logic [vgpm_pkg::DATA_BITS-1:0] prdata,
  output vgpm_pkg::cfg_t                 cfg
);
  import vgpm_pkg::*;

  logic                  wr_en;
  reg_idx_t              idx;
  logic [SX_BITS-1:0]    wx;
  logic [SY_BITS-1:0]    wy;
  logic [SZ_BITS-1:0]    wz;
  logic [SX_BITS-1:0]    size_x_r, size_x_nxt;
  logic [SY_BITS-1:0]    size_y_r, size_y_nxt;
  logic [SZ_BITS-1:0]    size_z_r, size_z_nxt;
  sample_t               dlim_r;
  logic [SCALE_BITS-1:0] scale_r;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wx    = pwdata[SX_BITS-1:0];
  assign wy    = pwdata[SY_BITS-1:0];
  assign wz    = pwdata[SZ_BITS-1:0];

  always_comb begin
    size_x_nxt = (wx < SX_BITS'(1)) ? SX_BITS'(1) :
                 (wx > SX_BITS'(MAX_SIZE_X)) ? SX_BITS'(MAX_SIZE_X) : wx;
    size_y_nxt = (wy < SY_BITS'(1)) ? SY_BITS'(1) :
                 (wy > SY_BITS'(MAX_SIZE_Y)) ? SY_BITS'(MAX_SIZE_Y) : wy;
    size_z_nxt = (wz < SZ_BITS'(MIN_SIZE_Z)) ? SZ_BITS'(MIN_SIZE_Z) :
                 (wz > SZ_BITS'(MAX_SIZE_Z)) ? SZ_BITS'(MAX_SIZE_Z) : wz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= RST_SIZE_X;
      size_y_r <= RST_SIZE_Y;
      size_z_r <= RST_SIZE_Z;
      dlim_r   <= sample_t'(Q_MAX[SAMPLE_BITS-1:0]);
      scale_r  <= RST_SCALE;
    end else if (wr_en) begin
      case (idx)
        REG_SIZE_X:         size_x_r <= size_x_nxt;
        REG_SIZE_Y:         size_y_r <= size_y_nxt;
        REG_SIZE_Z:         size_z_r <= size_z_nxt;
        REG_DUMMY_LIMIT:    dlim_r   <= sample_t'(pwdata[SAMPLE_BITS-1:0]);
        REG_GRADIENT_SCALE: scale_r  <= pwdata[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIZE_X:         prdata = DATA_BITS'(size_x_r);
      REG_SIZE_Y:         prdata = DATA_BITS'(size_y_r);
      REG_SIZE_Z:         prdata = DATA_BITS'(size_z_r);
      REG_DUMMY_LIMIT:    prdata = DATA_BITS'($unsigned(dlim_r));
      REG_GRADIENT_SCALE: prdata = DATA_BITS'(scale_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg.size_x         = size_x_r;
    cfg.size_y         = size_y_r;
    cfg.size_z         = size_z_r;
    cfg.dummy_limit    = dlim_r;
    cfg.gradient_scale = scale_r;
    // a size write starts a new volume
    cfg.restart        = wr_en &&
                         (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z);
  end

endmodule
`default_nettype wire

[sv/vertical_gradient_peak_marker.sv]
// Vertical gradient and z-peak marker over a raster-ordered volume stream.
// in_*  : one sample transfer per voxel, x fastest, then y, then z. tuser
//         set marks a flush item; flushes are dropped until the volume's last
//         plane is in, then two planes of items (of either kind) drain it.
// out_* : one result per item from plane 2 on, for the voxel two planes back:
//         gradient and peak values in tdata, their dummy flags in tuser, tlast
//         on the final voxel of the volume.
// cfg_* : register port; size writes restart the volume at voxel zero.
// Throughput is one item per cycle while the output is not stalled. An item
// passes the input register with plane-buffer read, difference, multiply,
// round/saturate with gradient-buffer read, and peak compare into the output reg.
// Each plane buffer is a RAM read on stage entry and written on stage exit,
// with the last write bypassed, so single-voxel planes also run at full rate.
// A stalled receiver holds the output register; the pipeline keeps taking
// items until its stages fill, then in_tready drops.
// Reset empties the pipeline and sets the position to voxel zero; plane
// buffer contents are not cleared and are only used after being written.
`default_nettype none
`include "vertical_gradient_peak_marker_assert.svh"
module vertical_gradient_peak_marker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [vgpm_pkg::IN_DATA_BITS-1:0]  in_tdata,    // sample_value
  input  logic [0:0]                         in_tuser,    // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [vgpm_pkg::OUT_DATA_BITS-1:0] out_tdata,   // gradient_value, peak_value
  output logic [1:0]                         out_tuser,   // gradient_dummy, peak_dummy
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [vgpm_pkg::ADDR_BITS-1:0]     cfg_paddr,
  input  logic [vgpm_pkg::DATA_BITS-1:0]     cfg_pwdata,
  output logic [vgpm_pkg::DATA_BITS-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import vgpm_pkg::*;

  cfg_t cfg;

  // position
  logic [X_BITS-1:0]    pos_x_r, pos_x_nxt;
  logic [Y_BITS-1:0]    pos_y_r, pos_y_nxt;
  logic [Z_BITS-1:0]    pos_z_r, pos_z_nxt;
  logic                 x_end, y_end, z_wrap;
  logic                 drain_in, ignore_in, in_xfer, s1_ld;
  logic [CELL_BITS-1:0] vox_in;

  // handshake
  logic out_free, r1, r2, r3, r4, x12, x23, x34, x4o;
  logic v1_r, v2_r, v3_r, v4_r, ov_r;

  // stage 1
  logic [CELL_BITS-1:0] s1_vox_r;
  sample_t              s1_sample_r;
  logic                 s1_drain_r, s1_grad_ok_r, s1_has_out_r, s1_peak_pl_r, s1_last_r;
  logic [2*SAMPLE_BITS-1:0] in_rd, in_fwd, in_wdata;
  sample_t              back1, back2;
  logic                 fresh_ok;
  logic signed [DIFF_BITS-1:0] diff;
  logic                 iw_v_r;
  logic [CELL_BITS-1:0] iw_addr_r;
  logic [2*SAMPLE_BITS-1:0] iw_data_r;

  // stage 2
  logic [CELL_BITS-1:0] s2_vox_r;
  logic signed [DIFF_BITS-1:0] s2_diff_r;
  logic                 s2_fresh_ok_r, s2_has_out_r, s2_peak_pl_r, s2_last_r;
  logic signed [SCALE_BITS:0]  scale_s;
  logic signed [PROD_BITS-1:0] prod;

  // stage 3
  logic [CELL_BITS-1:0] s3_vox_r;
  logic signed [PROD_BITS-1:0] s3_prod_r, rnd, q;
  logic                 s3_fresh_ok_r, s3_has_out_r, s3_peak_pl_r, s3_last_r;
  sample_t              q_sat;
  grad_t                fresh, here, below;
  logic [2*GRAD_BITS-1:0] g_rd, g_fwd, g_wdata;
  logic                 gw_v_r;
  logic [CELL_BITS-1:0] gw_addr_r;
  logic [2*GRAD_BITS-1:0] gw_data_r;

  // stage 4 and output
  grad_t   s4_here_r, s4_below_r, s4_fresh_r;
  logic    s4_has_out_r, s4_peak_pl_r, s4_last_r;
  logic    peak;
  sample_t out_grad_r, out_peak_r;
  logic    out_gdum_r, out_pdum_r, out_last_r;

  logic [X_BITS:0] pos_x_ext;
  logic [ZE_BITS-1:0] pos_z_ext;

  vgpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // ---------------- input side ----------------
  assign drain_in  = pos_z_r >= cfg.size_z;
  assign ignore_in = !drain_in && in_tuser[0];
  assign in_xfer   = in_tvalid && r1;
  assign s1_ld     = in_xfer && !ignore_in;
  assign vox_in    = {pos_y_r, pos_x_r};

  assign x_end  = (SX_BITS'(pos_x_r) + SX_BITS'(1)) >= cfg.size_x;
  assign y_end  = (SY_BITS'(pos_y_r) + SY_BITS'(1)) >= cfg.size_y;
  assign z_wrap = (ZE_BITS'(pos_z_r) + ZE_BITS'(1)) >= (ZE_BITS'(cfg.size_z) + ZE_BITS'(2));

  always_comb begin
    pos_x_nxt = pos_x_r + X_BITS'(1);
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (x_end) begin
      pos_x_nxt = '0;
      pos_y_nxt = pos_y_r + Y_BITS'(1);
      if (y_end) begin
        pos_y_nxt = '0;
        pos_z_nxt = z_wrap ? '0 : pos_z_r + Z_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else if (s1_ld) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  // ---------------- pipeline flow ----------------
  assign out_free  = !ov_r || out_tready;
  assign r4        = !v4_r || !s4_has_out_r || out_free;
  assign r3        = !v3_r || r4;
  assign r2        = !v2_r || r3;
  assign r1        = !v1_r || r2;
  assign x12       = v1_r && r2;
  assign x23       = v2_r && r3;
  assign x34       = v3_r && r4;
  assign x4o       = v4_r && r4;
  assign in_tready = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      ov_r   <= 1'b0;
      iw_v_r <= 1'b0;
      gw_v_r <= 1'b0;
    end else begin
      v1_r <= s1_ld ? 1'b1 : (x12 ? 1'b0 : v1_r);
      v2_r <= x12 ? 1'b1 : (x23 ? 1'b0 : v2_r);
      v3_r <= x23 ? 1'b1 : (x34 ? 1'b0 : v3_r);
      v4_r <= x34 ? 1'b1 : (x4o ? 1'b0 : v4_r);
      ov_r <= (x4o && s4_has_out_r) ? 1'b1 : (out_tready ? 1'b0 : ov_r);
      if (x12) begin
        iw_v_r <= 1'b1;
      end
      if (x34) begin
        gw_v_r <= 1'b1;
      end
    end
  end

  // ---------------- stage 1: input planes, difference ----------------
  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_vox_r     <= vox_in;
      s1_sample_r  <= sample_t'(in_tdata[SAMPLE_BITS-1:0]);
      s1_drain_r   <= drain_in;
      s1_grad_ok_r <= !drain_in && pos_z_r >= Z_BITS'(2);
      s1_has_out_r <= pos_z_r >= Z_BITS'(2);
      s1_peak_pl_r <= pos_z_r >= Z_BITS'(4) && pos_z_r < cfg.size_z;
      s1_last_r    <= (ZE_BITS'(pos_z_r) == ZE_BITS'(cfg.size_z) + ZE_BITS'(1)) &&
                      y_end && x_end;
    end
  end

  vgpm_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (PLANE_SIZE)
  ) u_in_ram (
    .clk   (clk),
    .we    (x12),
    .waddr (s1_vox_r),
    .wdata (in_wdata),
    .re    (s1_ld),
    .raddr (vox_in),
    .rdata (in_rd)
  );

  // layout {back2, back1}
  always_comb begin
    in_fwd   = (iw_v_r && iw_addr_r == s1_vox_r) ? iw_data_r : in_rd;
    back1    = in_fwd[SAMPLE_BITS-1:0];
    back2    = in_fwd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    in_wdata = s1_drain_r ? in_fwd : {back1, s1_sample_r};
    fresh_ok = s1_grad_ok_r && (s1_sample_r < cfg.dummy_limit) &&
               (back2 < cfg.dummy_limit);
    diff     = DIFF_BITS'(s1_sample_r) - DIFF_BITS'(back2);
  end

  always_ff @(posedge clk) begin
    if (x12) begin
      iw_addr_r     <= s1_vox_r;
      iw_data_r     <= in_wdata;
      s2_vox_r      <= s1_vox_r;
      s2_diff_r     <= diff;
      s2_fresh_ok_r <= fresh_ok;
      s2_has_out_r  <= s1_has_out_r;
      s2_peak_pl_r  <= s1_peak_pl_r;
      s2_last_r     <= s1_last_r;
    end
  end

  // ---------------- stage 2: scale ----------------
  assign scale_s = $signed({1'b0, cfg.gradient_scale});
  assign prod    = s2_diff_r * scale_s;

  always_ff @(posedge clk) begin
    if (x23) begin
      s3_vox_r      <= s2_vox_r;
      s3_prod_r     <= prod;
      s3_fresh_ok_r <= s2_fresh_ok_r;
      s3_has_out_r  <= s2_has_out_r;
      s3_peak_pl_r  <= s2_peak_pl_r;
      s3_last_r     <= s2_last_r;
    end
  end

  // ---------------- stage 3: round, saturate, gradient planes ----------------
  vgpm_ram #(
    .WIDTH (2 * GRAD_BITS),
    .DEPTH (PLANE_SIZE)
  ) u_grad_ram (
    .clk   (clk),
    .we    (x34),
    .waddr (s3_vox_r),
    .wdata (g_wdata),
    .re    (x23),
    .raddr (s2_vox_r),
    .rdata (g_rd)
  );

  // layout {back3, back2}
  always_comb begin
    rnd   = s3_prod_r + ROUND_BIAS;
    q     = rnd >>> ROUND_SHIFT;
    q_sat = (q > Q_MAX) ? sample_t'(Q_MAX[SAMPLE_BITS-1:0]) :
            (q < Q_MIN) ? sample_t'(Q_MIN[SAMPLE_BITS-1:0]) :
                          sample_t'(q[SAMPLE_BITS-1:0]);
    fresh.dummy = !s3_fresh_ok_r;
    fresh.value = s3_fresh_ok_r ? q_sat : '0;
    g_fwd   = (gw_v_r && gw_addr_r == s3_vox_r) ? gw_data_r : g_rd;
    here    = grad_t'(g_fwd[GRAD_BITS-1:0]);
    below   = grad_t'(g_fwd[2*GRAD_BITS-1:GRAD_BITS]);
    g_wdata = {here, fresh};
  end

  always_ff @(posedge clk) begin
    if (x34) begin
      gw_addr_r    <= s3_vox_r;
      gw_data_r    <= g_wdata;
      s4_here_r    <= here;
      s4_below_r   <= below;
      s4_fresh_r   <= fresh;
      s4_has_out_r <= s3_has_out_r;
      s4_peak_pl_r <= s3_peak_pl_r;
      s4_last_r    <= s3_last_r;
    end
  end

  // ---------------- stage 4: peak test into output register ----------------
  // dummy acts as +inf, so any dummy neighbor rules out a peak
  assign peak = s4_peak_pl_r && !s4_here_r.dummy && !s4_below_r.dummy &&
                !s4_fresh_r.dummy && (s4_here_r.value > s4_below_r.value) &&
                (s4_here_r.value > s4_fresh_r.value);

  always_ff @(posedge clk) begin
    if (x4o && s4_has_out_r) begin
      out_grad_r <= s4_here_r.dummy ? '0 : s4_here_r.value;
      out_gdum_r <= s4_here_r.dummy;
      out_peak_r <= peak ? s4_here_r.value : '0;
      out_pdum_r <= !peak;
      out_last_r <= s4_last_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_DATA_BITS'({out_peak_r, out_grad_r});
  assign out_tuser  = {out_pdum_r, out_gdum_r};
  assign out_tlast  = out_last_r;

  // ---------------- checks ----------------
  assign pos_x_ext = {1'b0, pos_x_r};
  assign pos_z_ext = ZE_BITS'(pos_z_r);

  `VGPM_ASSERT_NEXT(a_early_flush_dropped, clk, rst_n, in_xfer && ignore_in, !v1_r, "early flush entered the pipeline")
  `VGPM_ASSERT(a_last_is_dummy, clk, rst_n, !(out_tvalid && out_tlast) || (out_tuser == 2'b11), "final voxel result not dummy")
  `VGPM_ASSERT(a_pos_in_range, clk, rst_n, (pos_x_ext < cfg.size_x) && (pos_z_ext <= ZE_BITS'(cfg.size_z) + ZE_BITS'(1)), "position outside volume")

endmodule
`default_nettype wire

[verif/tb_vertical_gradient_peak_marker.sv]
`timescale 1ns / 1ps
module tb_vertical_gradient_peak_marker;
  import vgpm_pkg::*;

  localparam int      CYCLE_LIMIT   = 400000;
  localparam int      SETTLE_CYCLES = 12;
  localparam int      REPORT_CAP    = 20;
  localparam sample_t SAMPLE_MAX    = 24'sh7fffff;
  localparam sample_t SAMPLE_MIN    = 24'sh800000;

  typedef struct {
    longint value;
    bit     dummy;
  } zgrad_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] grad_value;
    logic                   grad_dummy;
    logic [SAMPLE_BITS-1:0] peak_value;
    logic                   peak_dummy;
    logic                   last_voxel;
  } voxel_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;    // sample_value
  logic [0:0]               in_tuser;    // command
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;   // gradient_value, peak_value
  logic [1:0]               out_tuser;   // gradient_dummy, peak_dummy
  logic                     out_tlast;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [ADDR_BITS-1:0]     cfg_paddr;
  logic [DATA_BITS-1:0]     cfg_pwdata;
  logic [DATA_BITS-1:0]     cfg_prdata;
  logic                     cfg_pready;

  vertical_gradient_peak_marker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // volume geometry, levels and stream position as the block should see them
  int     vol_nx = MAX_SIZE_X;
  int     vol_ny = MAX_SIZE_Y;
  int     vol_nz = MAX_SIZE_Z;
  longint dummy_floor = 8388607;
  longint grad_scale = 256;
  int     pos_x = 0;
  int     pos_y = 0;
  int     pos_z = 0;

  longint sample_back1 [PLANE_SIZE];
  longint sample_back2 [PLANE_SIZE];
  zgrad_t grad_back2   [PLANE_SIZE];
  zgrad_t grad_back3   [PLANE_SIZE];

  voxel_result_t pending_voxels[$];

  int burst_left      = 0;
  int cycle_count     = 0;
  int mismatch_count  = 0;
  int results_checked = 0;
  int transfers_sent  = 0;
  int stimulus_items  = 0;
  int volumes_done    = 0;
  int peaks_seen      = 0;
  int volume_ends     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint scaled_gradient(longint diff);
    longint q;
    q = (diff * grad_scale + 128) >>> 8;
    if (q > longint'(SAMPLE_MAX)) q = SAMPLE_MAX;
    if (q < longint'(SAMPLE_MIN)) q = SAMPLE_MIN;
    return q;
  endfunction

  function automatic bit predict_voxel(bit flush, sample_t s, output voxel_result_t r);
    int     vox_idx;
    int     k;
    bit     draining;
    bit     produced;
    bit     is_peak;
    longint cur;
    zgrad_t fresh;
    zgrad_t here;
    zgrad_t under;
    r = '0;
    produced = 1'b0;
    draining = pos_z >= vol_nz;
    if (flush && !draining) return 1'b0;
    vox_idx = pos_y * MAX_SIZE_X + pos_x;
    cur = s;
    fresh.value = 0;
    fresh.dummy = 1'b1;
    if (!draining && pos_z >= 2 && pos_z <= vol_nz - 1 &&
        cur < dummy_floor && sample_back2[vox_idx] < dummy_floor) begin
      fresh.value = scaled_gradient(cur - sample_back2[vox_idx]);
      fresh.dummy = 1'b0;
    end
    if (pos_z >= 2) begin
      k = pos_z - 2;
      here = grad_back2[vox_idx];
      under = grad_back3[vox_idx];
      is_peak = k >= 2 && k + 3 <= vol_nz && !here.dummy && !under.dummy && !fresh.dummy &&
                here.value > under.value && here.value > fresh.value;
      r.grad_value = here.dummy ? '0 : here.value[SAMPLE_BITS-1:0];
      r.grad_dummy = here.dummy;
      r.peak_value = is_peak ? here.value[SAMPLE_BITS-1:0] : '0;
      r.peak_dummy = !is_peak;
      r.last_voxel = (k + 1 == vol_nz) && (pos_y + 1 >= vol_ny) && (pos_x + 1 >= vol_nx);
      produced = 1'b1;
    end
    grad_back3[vox_idx] = grad_back2[vox_idx];
    grad_back2[vox_idx] = fresh;
    if (!draining) begin
      sample_back2[vox_idx] = sample_back1[vox_idx];
      sample_back1[vox_idx] = cur;
    end
    pos_x++;
    if (pos_x >= vol_nx) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= vol_ny) begin
        pos_y = 0;
        pos_z++;
        if (pos_z >= vol_nz + 2) pos_z = 0;
      end
    end
    return produced;
  endfunction

  function automatic void record_register(reg_idx_t r, logic [31:0] v);
    int f;
    case (r)
      REG_SIZE_X: begin
        f = int'(v[SX_BITS-1:0]);
        vol_nx = (f < 1) ? 1 : (f > MAX_SIZE_X) ? MAX_SIZE_X : f;
      end
      REG_SIZE_Y: begin
        f = int'(v[SY_BITS-1:0]);
        vol_ny = (f < 1) ? 1 : (f > MAX_SIZE_Y) ? MAX_SIZE_Y : f;
      end
      REG_SIZE_Z: begin
        f = int'(v[SZ_BITS-1:0]);
        vol_nz = (f < MIN_SIZE_Z) ? MIN_SIZE_Z : (f > MAX_SIZE_Z) ? MAX_SIZE_Z : f;
      end
      REG_DUMMY_LIMIT: dummy_floor = longint'($signed(v[SAMPLE_BITS-1:0]));
      REG_GRADIENT_SCALE: grad_scale = longint'(v[SCALE_BITS-1:0]);
      default: ;
    endcase
    if (r == REG_SIZE_X || r == REG_SIZE_Y || r == REG_SIZE_Z) begin
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
    end
  endfunction

  function automatic sample_t rand_sample();
    int     pick;
    longint v;
    pick = $urandom_range(0, 99);
    if (pick < 8) return sample_t'($urandom());
    if (pick < 12) return pick[0] ? SAMPLE_MAX : SAMPLE_MIN;
    if (pick < 18) begin
      // right at the dummy threshold
      v = dummy_floor + longint'($urandom_range(0, 2)) - 1;
      if (v > longint'(SAMPLE_MAX)) v = SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN)) v = SAMPLE_MIN;
      return sample_t'(v);
    end
    return sample_t'(longint'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic sample_t random_limit();
    case ($urandom_range(0, 4))
      0, 1: return SAMPLE_MAX;
      2: return sample_t'($urandom());
      3: return sample_t'($urandom_range(1000, 2000));
      default: return sample_t'(longint'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [15:0] random_scale();
    case ($urandom_range(0, 4))
      0: return 16'd256;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 1));
      default: return 16'($urandom_range(16, 1024));
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("ERROR result %0d: %s was 0x%0h, predicted 0x%0h",
               results_checked, field, got, want);
  endtask

  always @(posedge clk) begin : result_checker
    voxel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_voxels.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(out_tdata[SAMPLE_BITS-1:0]), '0);
      end else begin
        want = pending_voxels.pop_front();
        if (out_tdata[SAMPLE_BITS-1:0] !== want.grad_value)
          report_mismatch("gradient_value", 32'(out_tdata[SAMPLE_BITS-1:0]),
                          32'(want.grad_value));
        if (out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.peak_value)
          report_mismatch("peak_value", 32'(out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
                          32'(want.peak_value));
        if (out_tuser[0] !== want.grad_dummy)
          report_mismatch("gradient_dummy", 32'(out_tuser[0]), 32'(want.grad_dummy));
        if (out_tuser[1] !== want.peak_dummy)
          report_mismatch("peak_dummy", 32'(out_tuser[1]), 32'(want.peak_dummy));
        if (out_tlast !== want.last_voxel)
          report_mismatch("last_voxel", 32'(out_tlast), 32'(want.last_voxel));
        if (!want.peak_dummy) peaks_seen++;
        if (want.last_voxel) volume_ends++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_voxels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver backpressure: switches between free flow, random, sparse and long stalls
  initial begin : receiver_stalls
    int mode;
    int left;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (left % 5 == 0);
        default: out_tready <= (left % 12) < 3;
      endcase
    end
  end

  task automatic write_register(reg_idx_t r, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    record_register(r, v);
    @(posedge clk);
  endtask

  task automatic set_volume(int nx, int ny, int nz);
    write_register(REG_SIZE_X, 32'(nx));
    write_register(REG_SIZE_Y, 32'(ny));
    write_register(REG_SIZE_Z, 32'(nz));
  endtask

  task automatic set_levels(sample_t limit, logic [15:0] scale);
    write_register(REG_DUMMY_LIMIT, 32'(limit));
    write_register(REG_GRADIENT_SCALE, {16'h0, scale});
  endtask

  task automatic send_item(bit flush, sample_t s);
    int            gap;
    voxel_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    transfers_sent++;
    if (predict_voxel(flush, s, res)) pending_voxels.push_back(res);
  endtask

  // stop sending until every predicted result has been seen, then let the pipe settle
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_voxels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic stream_volume(bit cut_short);
    int plane_cells;
    int total;
    int stop_at;
    int i;
    plane_cells = vol_nx * vol_ny;
    total = plane_cells * (vol_nz + 2);
    stop_at = total;
    if (cut_short) begin
      stop_at = plane_cells * 2 + $urandom_range(1, plane_cells / 8 + 1);
      if (stop_at > total - 1) stop_at = total - 1;
    end
    for (i = 0; i < stop_at; i++) begin
      if (i < plane_cells * vol_nz) begin
        if ($urandom_range(0, 15) == 0) send_item(1'b1, rand_sample());
        send_item(1'b0, rand_sample());
      end else begin
        send_item(1'($urandom_range(0, 1)), rand_sample());
      end
      stimulus_items++;
      if (i == total / 2 && $urandom_range(0, 3) == 0) hold_until_drained();
    end
    if (!cut_short) volumes_done++;
  endtask

  // single column with one clear peak along z, plus flushes in every phase
  task automatic test_peak_profile();
    sample_t profile [7] = '{24'sd0, 24'sd0, 24'sd100, 24'sd300, 24'sd300, 24'sd300, 24'sd300};
    hold_until_drained();
    set_volume(1, 1, 7);
    set_levels(SAMPLE_MAX, 16'd256);
    send_item(1'b1, 24'sd0);
    foreach (profile[i]) send_item(1'b0, profile[i]);
    send_item(1'b0, 24'sd12345);
    send_item(1'b1, 24'sd0);
    send_item(1'b1, 24'sd0);
    stimulus_items += 11;
    volumes_done++;
  endtask

  // full-scale swings with the largest scale, and a sample at the dummy limit
  task automatic test_saturation();
    sample_t swing [10] = '{SAMPLE_MIN, 24'sd8388606, 24'sd5, -24'sd5, 24'sd8388606,
                            SAMPLE_MIN, 24'sd0, SAMPLE_MAX, -24'sd1, 24'sd1};
    hold_until_drained();
    set_volume(2, 1, 5);
    set_levels(SAMPLE_MAX, 16'hffff);
    foreach (swing[i]) begin
      send_item(1'b0, swing[i]);
      if (i == 5) hold_until_drained();
    end
    send_item(1'b1, 24'sd0);
    send_item(1'b0, 24'sd777);
    send_item(1'b1, 24'sd0);
    send_item(1'b0, -24'sd777);
    stimulus_items += 14;
    volumes_done++;
  endtask

  task automatic test_size_extremes();
    hold_until_drained();
    set_levels(SAMPLE_MIN, 16'd0);
    set_volume(2, 2, 5);
    stream_volume(1'b0);
    hold_until_drained();
    set_levels(SAMPLE_MAX, 16'd256);
    set_volume(511, 0, 0);
    stream_volume(1'b1);
    hold_until_drained();
    set_volume(0, 0, 2047);
    stream_volume(1'b1);
  endtask

  task automatic test_random_volumes();
    int start_items;
    int reps;
    int r;
    bit cut;
    start_items = stimulus_items;
    while (stimulus_items - start_items < 400) begin
      hold_until_drained();
      set_volume(($urandom_range(0, 4) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5),
                 $urandom_range(1, 4), $urandom_range(5, 9));
      if ($urandom_range(0, 1) == 0) set_levels(random_limit(), random_scale());
      reps = $urandom_range(1, 2);
      for (r = 0; r < reps; r++) begin
        cut = (r == reps - 1) && ($urandom_range(0, 7) == 0);
        stream_volume(cut);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_peak_profile();
    test_saturation();
    test_size_extremes();
    test_random_volumes();
    hold_until_drained();
    $display("Run sent %0d transfers over %0d complete volumes; %0d results checked, %0d peaks, %0d volume ends.",
             transfers_sent, volumes_done, results_checked, peaks_seen, volume_ends);
    $display("Sizes ranged from single voxel columns to 256-wide rows, with clamped size writes, early flushes and drain items under random stalls.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/vgpm_pkg.sv
sv/vgpm_ram.sv
sv/vgpm_cfg.sv
sv/vertical_gradient_peak_marker.sv
verif/tb_vertical_gradient_peak_marker.sv
